### src/wgem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgem_pkg
// Types and constants of the wraparound gradient edge map.
// ----------------------------------------------------------------------------
package wgem_pkg;

	localparam int FRAME_WIDTH_W  = 10;
	localparam int FRAME_HEIGHT_W = 13;
	localparam int CFG_DATA_W     = 13;
	localparam int CFG_INDEX_W    = 2;
	localparam int ROW_W          = 12;
	localparam int COL_OUT_W      = 9;

	localparam logic [FRAME_HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;
	localparam logic [FRAME_WIDTH_W-1:0]  WIDTH_RESET  = 10'd512;
	localparam logic [FRAME_HEIGHT_W-1:0] HEIGHT_RESET = 13'd512;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} cfg_reg_t;

	// Slots of the per-pixel result set, in emission order
	localparam int RES_ABOVE = 0;
	localparam int RES_LEFT  = 1;
	localparam int RES_FINAL = 2;
	localparam int RES_N     = 3;

endpackage

### src/wgem_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgem_if
// Valid/ready stream interfaces for pixels in and edge results out.
// ----------------------------------------------------------------------------
interface wgem_pixel_if #(
	parameter int PIXEL_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface wgem_edge_if #(
	parameter int PIXEL_BITS = 16
);
	logic                           valid;
	logic                           ready;
	logic [PIXEL_BITS-1:0]          edge_value;
	logic [wgem_pkg::ROW_W-1:0]     out_row;
	logic [wgem_pkg::COL_OUT_W-1:0] out_column;
	logic                           last_of_run;
	logic                           frame_done;

	modport source (output valid, output edge_value, output out_row, output out_column,
		output last_of_run, output frame_done, input ready);
	modport sink (input valid, input edge_value, input out_row, input out_column,
		input last_of_run, input frame_done, output ready);
endinterface

### src/wraparound_gradient_edge_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wraparound_gradient_edge_map
// Streaming forward-difference edge map with wraparound frame borders.
// ----------------------------------------------------------------------------
// Usage:
//   pixels : grayscale pixels in raster order, one per transfer.
//   edges  : (|right - p| + |below - p|) / 2 with row and column of p,
//            last_of_run on the final result of one input, frame_done on the
//            result of the last pixel of the frame.
//   write_enable / reg_index / write_data : frame_width (0), frame_height (1).
//            A write restarts the frame; write only while the block is idle.
// Results of row r appear while row r+1 arrives; the last row also yields its
// own results, and the final pixel closes the frame.
// Each result is formed in the pixel stage and then held in the output register.
// Throughput: one pixel per cycle while the output does not stall; a pixel with
// n results holds the input until its last result is taken (up to two in the
// last row, three for the final pixel): the single output register takes one
// result a cycle while the receiver is ready. The previous row and the first
// row sit in two one-port-read memories of MAX_WIDTH entries; each pixel reads
// both and writes the previous row, and the first row only while in row 0.
// Reset: counters and border pixels clear, sizes return to 512 x 512; memory
// content is kept and needs no clearing.
// A stalled receiver holds the output register, then the pixel stage, then
// pixels.ready.
// ----------------------------------------------------------------------------
module wraparound_gradient_edge_map #(
	parameter int MAX_WIDTH  = 512,
	parameter int PIXEL_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	wgem_pixel_if.sink                        pixels,
	wgem_edge_if.source                       edges,
	input  logic                              write_enable,
	input  logic [wgem_pkg::CFG_INDEX_W-1:0]  reg_index,
	input  logic [wgem_pkg::CFG_DATA_W-1:0]   write_data
);

	localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMPW = 14;
	localparam int HW   = wgem_pkg::FRAME_HEIGHT_W;
	localparam int RW   = wgem_pkg::ROW_W;
	localparam int PW   = PIXEL_BITS;
	localparam int RN   = wgem_pkg::RES_N;

	// configuration and position
	logic [wgem_pkg::FRAME_WIDTH_W-1:0]  frame_width_q;
	logic [HW-1:0]                       frame_height_q;
	logic [CW-1:0]                       col_q;
	logic [RW-1:0]                       row_q;
	logic [PW-1:0]                       cur_first_q;
	logic [PW-1:0]                       prev_first_q;

	logic [CMPW-1:0] fw_ext;
	logic [CW:0]     w_eff;
	logic [HW-1:0]   h_eff;
	logic            out_of_range;
	logic [CW-1:0]   c_pos;
	logic [RW-1:0]   r_pos;
	logic            last_col;
	logic            last_row;
	logic            acc;

	// memories
	logic [PW-1:0] prev_mem [0:MAX_WIDTH-1];
	logic [PW-1:0] first_mem [0:MAX_WIDTH-1];
	logic [PW-1:0] prev_rd_q;
	logic [PW-1:0] fr_rd_q;

	// pixel stage
	logic          s1_valid_q;
	logic [RN-1:0] pend_s1;
	logic [PW-1:0] pix_s1;
	logic [PW-1:0] prevpix_s1;
	logic [PW-1:0] up_s1;
	logic [PW-1:0] fr_left_s1;
	logic [PW-1:0] prev_first_s1;
	logic [PW-1:0] cur_first_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic          last_col_s1;

	// output register
	logic                           out_valid_q;
	logic [PW-1:0]                  out_edge_q;
	logic [RW-1:0]                  out_row_q;
	logic [wgem_pkg::COL_OUT_W-1:0] out_col_q;
	logic                           out_last_q;
	logic                           out_done_q;

	logic          out_free;
	logic          fire;
	logic          s1_finish;
	logic [RN-1:0] sel;
	logic [RN-1:0] rem;
	logic [PW-1:0] op_p;
	logic [PW-1:0] op_right;
	logic [PW-1:0] op_below;
	logic [PW-1:0] fr_here;
	logic [PW-1:0] diff_r;
	logic [PW-1:0] diff_b;
	logic [PW:0]   sum_rb;
	logic [RW-1:0] res_row;
	logic [CW-1:0] res_col;

	always_comb begin
		fw_ext = CMPW'(frame_width_q);
		if (fw_ext == '0) begin
			w_eff = (CW+1)'(1);
		end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
			w_eff = (CW+1)'(MAX_WIDTH);
		end else begin
			w_eff = (CW+1)'(fw_ext);
		end
		if (frame_height_q == '0) begin
			h_eff = HW'(1);
		end else if (frame_height_q > wgem_pkg::HEIGHT_LIMIT) begin
			h_eff = wgem_pkg::HEIGHT_LIMIT;
		end else begin
			h_eff = frame_height_q;
		end
		out_of_range = ((CW+1)'(col_q) >= w_eff) || (HW'(row_q) >= h_eff);
		c_pos = out_of_range ? '0 : col_q;
		r_pos = out_of_range ? '0 : row_q;
		last_col = ((CW+1)'(c_pos) + (CW+1)'(1)) == w_eff;
		last_row = (HW'(r_pos) + HW'(1)) == h_eff;
	end

	assign out_free  = !out_valid_q || edges.ready;
	assign fire      = s1_valid_q && (pend_s1 != '0) && out_free;
	assign rem       = pend_s1 & ~sel;
	assign s1_finish = s1_valid_q && ((pend_s1 == '0) || (fire && (rem == '0)));
	assign pixels.ready = !s1_valid_q || s1_finish;
	assign acc = pixels.valid && pixels.ready;

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= wgem_pkg::WIDTH_RESET;
			frame_height_q <= wgem_pkg::HEIGHT_RESET;
			col_q          <= '0;
			row_q          <= '0;
			cur_first_q    <= '0;
			prev_first_q   <= '0;
		end else begin
			if (acc) begin
				if (c_pos == '0) begin
					prev_first_q <= cur_first_q;
					cur_first_q  <= pixels.pixel;
				end
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : r_pos + RW'(1);
				end else begin
					col_q <= c_pos + CW'(1);
					row_q <= r_pos;
				end
			end
			if (write_enable) begin
				case (reg_index)
					wgem_pkg::REG_FRAME_WIDTH: begin
						frame_width_q <= write_data[wgem_pkg::FRAME_WIDTH_W-1:0];
						col_q         <= '0;
						row_q         <= '0;
					end
					wgem_pkg::REG_FRAME_HEIGHT: begin
						frame_height_q <= write_data;
						col_q          <= '0;
						row_q          <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// row memories: write this pixel, read the previous row ahead
	always_ff @(posedge clk) begin
		if (acc) begin
			prev_mem[c_pos] <= pixels.pixel;
			if (r_pos == '0) begin
				first_mem[c_pos] <= pixels.pixel;
			end
			prev_rd_q <= prev_mem[c_pos + CW'(1)];
			fr_rd_q   <= first_mem[c_pos];
		end
	end

	// pixel stage payload
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1        <= pixels.pixel;
			prevpix_s1    <= pix_s1;
			up_s1         <= (c_pos == '0) ? ((c_pos == '0) ? cur_first_q : prev_first_q)
				: prev_rd_q;
			fr_left_s1    <= (row_s1 == '0) ? pix_s1 : fr_rd_q;
			prev_first_s1 <= (c_pos == '0) ? cur_first_q : prev_first_q;
			cur_first_s1  <= (c_pos == '0) ? pixels.pixel : cur_first_q;
			col_s1        <= c_pos;
			row_s1        <= r_pos;
			last_col_s1   <= last_col;
		end
	end

	// pixel stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			pend_s1    <= '0;
		end else begin
			if (acc) begin
				s1_valid_q                  <= 1'b1;
				pend_s1[wgem_pkg::RES_ABOVE] <= (r_pos != '0);
				pend_s1[wgem_pkg::RES_LEFT]  <= last_row && (c_pos != '0);
				pend_s1[wgem_pkg::RES_FINAL] <= last_row && last_col;
			end else if (s1_finish) begin
				s1_valid_q <= 1'b0;
				pend_s1    <= '0;
			end else if (fire) begin
				pend_s1 <= rem;
			end
		end
	end

	// pick the next pending result and its operands
	always_comb begin
		fr_here  = (row_s1 == '0) ? pix_s1 : fr_rd_q;
		sel      = '0;
		op_p     = pix_s1;
		op_right = cur_first_s1;
		op_below = fr_here;
		res_row  = row_s1;
		res_col  = col_s1;
		if (pend_s1[wgem_pkg::RES_ABOVE]) begin
			sel[wgem_pkg::RES_ABOVE] = 1'b1;
			op_p     = up_s1;
			op_right = last_col_s1 ? prev_first_s1 : prev_rd_q;
			op_below = pix_s1;
			res_row  = row_s1 - RW'(1);
		end else if (pend_s1[wgem_pkg::RES_LEFT]) begin
			sel[wgem_pkg::RES_LEFT] = 1'b1;
			op_p     = prevpix_s1;
			op_right = pix_s1;
			op_below = fr_left_s1;
			res_col  = col_s1 - CW'(1);
		end else begin
			sel[wgem_pkg::RES_FINAL] = pend_s1[wgem_pkg::RES_FINAL];
		end
		diff_r = (op_right > op_p) ? op_right - op_p : op_p - op_right;
		diff_b = (op_below > op_p) ? op_below - op_p : op_p - op_below;
		sum_rb = (PW+1)'(diff_r) + (PW+1)'(diff_b);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (edges.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_edge_q <= sum_rb[PW:1];
			out_row_q  <= res_row;
			out_col_q  <= wgem_pkg::COL_OUT_W'(res_col);
			out_last_q <= (rem == '0);
			out_done_q <= sel[wgem_pkg::RES_FINAL];
		end
	end

	assign edges.valid       = out_valid_q;
	assign edges.edge_value  = out_edge_q;
	assign edges.out_row     = out_row_q;
	assign edges.out_column  = out_col_q;
	assign edges.last_of_run = out_last_q;
	assign edges.frame_done  = out_done_q;

`ifndef NO_ASSERTIONS
	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		((CW+1)'(col_q) < w_eff) || write_enable || $past(write_enable))
		else $error("column counter outside frame width");

	a_pend_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> (pend_s1 == '0))
		else $error("pending results without a pixel in stage");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_done_q) |-> out_last_q)
		else $error("frame end result not last of its run");

	a_one_pick: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> ($onehot(sel) && ((sel & pend_s1) == sel)))
		else $error("result selection not one pending slot");
`endif

endmodule
